### design/ddf_pkg.sv
// ----------------------------------------------------------------------------
// Decimal digit display feeder package
// Shared widths, codes and the queue status type.
// ----------------------------------------------------------------------------
package ddf_pkg;

    localparam int VALUE_W         = 27;
    localparam int POS_W           = 4;
    localparam int CODE_W          = 4;
    localparam int CNT_W           = $clog2(VALUE_W);
    // Enough decimal digits to hold any 27-bit value without loss.
    localparam int MIN_CONV_DIGITS = 9;

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### design/ddf_front.sv
// ----------------------------------------------------------------------------
// Decimal digit display feeder front end
// Accepts a binary value and converts it to packed decimal digits by
// shift-and-add-three, one input bit per cycle.
// ----------------------------------------------------------------------------
module ddf_front #(
    parameter int CONV_DIGITS = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ddf_pkg::VALUE_W-1:0]       value,
    input  ddf_pkg::q_status_t                q_status,
    output logic                              q_push,
    output logic [4*CONV_DIGITS-1:0]          q_data
);

    localparam int BCD_W = 4 * CONV_DIGITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_HOLD
    } state_t;

    state_t                        state_reg;
    logic [ddf_pkg::CNT_W-1:0]     cnt_reg;
    logic [ddf_pkg::VALUE_W-1:0]   shift_reg;
    logic [BCD_W-1:0]              bcd_reg;
    logic [BCD_W-1:0]              bcd_adj;
    logic                          accept;

    assign accept = push && (state_reg == ST_IDLE);
    assign full   = (state_reg != ST_IDLE);
    assign q_push = (state_reg == ST_HOLD) && !q_status.full;
    assign q_data = bcd_reg;

    // Any digit of five or more is corrected before the doubling shift.
    always_comb
    begin
        for (int i = 0; i < CONV_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CONV;
                        cnt_reg   <= '0;
                    end
                end
                ST_CONV:
                begin
                    if (cnt_reg == ddf_pkg::CNT_W'(ddf_pkg::VALUE_W - 1))
                        state_reg <= ST_HOLD;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_HOLD:
                begin
                    if (!q_status.full)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            shift_reg <= value;
            bcd_reg   <= '0;
        end
        else if (state_reg == ST_CONV)
        begin
            bcd_reg   <= {bcd_adj[BCD_W-2:0], shift_reg[ddf_pkg::VALUE_W-1]};
            shift_reg <= {shift_reg[ddf_pkg::VALUE_W-2:0], 1'b0};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (cnt_reg < ddf_pkg::CNT_W'(ddf_pkg::VALUE_W)))
        else $error("conversion counter ran past the last input bit");
`endif

endmodule

### design/ddf_queue.sv
// ----------------------------------------------------------------------------
// Decimal digit display feeder queue
// Two-entry queue of converted digit words between front and back.
// ----------------------------------------------------------------------------
module ddf_queue #(
    parameter int CONV_DIGITS = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [4*CONV_DIGITS-1:0]    wr_data,
    input  logic                        pop,
    output logic [4*CONV_DIGITS-1:0]    rd_data,
    output ddf_pkg::q_status_t          status
);

    localparam int BCD_W = 4 * CONV_DIGITS;

    logic [BCD_W-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_data      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count exceeds its depth");
`endif

endmodule

### design/ddf_back.sv
// ----------------------------------------------------------------------------
// Decimal digit display feeder back end
// Turns one converted digit word into a run of digit-register writes.
// ----------------------------------------------------------------------------
module ddf_back #(
    parameter int DIGITS      = 8,
    parameter int CONV_DIGITS = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ddf_pkg::q_status_t            q_status,
    input  logic [4*CONV_DIGITS-1:0]      q_data,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [ddf_pkg::POS_W-1:0]     digit_position,
    output logic [ddf_pkg::CODE_W-1:0]    code,
    output logic                          last
);

    localparam int BCD_W = 4 * CONV_DIGITS;
    localparam logic [ddf_pkg::POS_W-1:0] LAST_POS = ddf_pkg::POS_W'(DIGITS);

    logic                          active_reg;
    logic [ddf_pkg::POS_W-1:0]     pos_reg;
    logic [BCD_W-1:0]              rest_reg;
    logic                          out_valid_reg;
    logic [ddf_pkg::POS_W-1:0]     position_reg;
    logic [ddf_pkg::CODE_W-1:0]    code_reg;
    logic                          last_reg;
    logic                          out_free;
    logic                          emit;

    assign out_free       = !out_valid_reg || pop;
    assign emit           = active_reg && out_free;
    assign q_pop          = !active_reg && !q_status.empty;
    assign empty          = !out_valid_reg;
    assign digit_position = position_reg;
    assign code           = code_reg;
    assign last           = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                active_reg <= 1'b1;
                pos_reg    <= ddf_pkg::POS_W'(1);
            end
            else if (emit)
            begin
                if (pos_reg == LAST_POS)
                    active_reg <= 1'b0;
                pos_reg <= pos_reg + 1'b1;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // A position is blank once no nonzero digit remains at or above it.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            rest_reg <= q_data;
        else if (emit)
            rest_reg <= rest_reg >> ddf_pkg::CODE_W;

        if (emit)
        begin
            position_reg <= pos_reg;
            code_reg     <= (rest_reg == '0) ? ddf_pkg::BLANK_CODE
                                             : rest_reg[ddf_pkg::CODE_W-1:0];
            last_reg     <= (pos_reg == LAST_POS);
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (pos_reg >= ddf_pkg::POS_W'(1)) && (pos_reg <= LAST_POS))
        else $error("digit position out of range while emitting");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (position_reg == LAST_POS))
        else $error("last flag set on a position other than the top one");
`endif

endmodule

### design/decimal_digit_display_feeder_unit.sv
// ----------------------------------------------------------------------------
// Decimal digit display feeder
// Converts a binary value into blanked decimal digit-register writes.
//
// Channel  Direction  Handshake       Payload
// -------  ---------  --------------  ----------------------------------
// input    in         push / full     value[26:0]
// result   out        empty / pop     digit_position[3:0], code[3:0], last
//
// The conversion takes one input bit per cycle; an item holds the front end
// through accept, 27 shift steps and hand-off; no new item is taken before
// hand-off. The back end issues DIGITS writes, one per cycle unless stalled.
// Reset clears all control state; no clearing pass is needed.
// A stalled result side fills the two-entry queue, then holds the front end.
// ----------------------------------------------------------------------------
module decimal_digit_display_feeder_unit #(
    parameter int DIGITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ddf_pkg::VALUE_W-1:0]   value,
    output logic                          empty,
    input  logic                          pop,
    output logic [ddf_pkg::POS_W-1:0]     digit_position,
    output logic [ddf_pkg::CODE_W-1:0]    code,
    output logic                          last
);

    localparam int CONV_DIGITS = (DIGITS > ddf_pkg::MIN_CONV_DIGITS)
                                 ? DIGITS : ddf_pkg::MIN_CONV_DIGITS;
    localparam int BCD_W       = 4 * CONV_DIGITS;

    ddf_pkg::q_status_t  q_status;
    logic                q_push;
    logic                q_pop;
    logic [BCD_W-1:0]    q_wr_data;
    logic [BCD_W-1:0]    q_rd_data;

    ddf_front #(
        .CONV_DIGITS (CONV_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .value    (value),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    ddf_queue #(
        .CONV_DIGITS (CONV_DIGITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    ddf_back #(
        .DIGITS      (DIGITS),
        .CONV_DIGITS (CONV_DIGITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .q_data         (q_rd_data),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .digit_position (digit_position),
        .code           (code),
        .last           (last)
    );

endmodule
